### rtl/tcc_pkg.sv
`timescale 1ns / 1ps
// Package for the text console engine: fixed field widths, control codes,
// register indexes and the command/status structs between controller and datapath.
// No dependencies.
package tcc_pkg;

    localparam int CHAR_W       = 16;
    localparam int COL_PORT_W   = 7;
    localparam int ROW_PORT_W   = 6;
    localparam int CFG_DATA_W   = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int WIDTH_CFG_W  = 8;
    localparam int HEIGHT_CFG_W = 7;

    localparam int RST_WIDTH  = 80;
    localparam int RST_HEIGHT = 25;

    localparam logic [CHAR_W-1:0] CH_BS  = 16'd8;
    localparam logic [CHAR_W-1:0] CH_TAB = 16'd9;
    localparam logic [CHAR_W-1:0] CH_LF  = 16'd10;
    localparam logic [CHAR_W-1:0] CH_CR  = 16'd13;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef struct packed {
        logic init_clear;
        logic accept;
        logic calc;
        logic exec;
        logic scroll_clear;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic init_last;
        logic need_scroll;
        logic clear_last;
    } dp_status_t;

endpackage

### rtl/tcc_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the text console engine: sequences clear sweep,
// item steps, row clear on scroll and the output register valid.
// Depends on tcc_pkg.
module tcc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  tcc_pkg::dp_status_t status,
    output tcc_pkg::dp_cmd_t    cmd
);
    import tcc_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CALC,
        S_EXEC,
        S_SCROLL,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT: begin
                cmd.init_clear = 1'b1;
                if (status.init_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                cmd.calc   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                if (status.need_scroll) begin
                    state_next = S_SCROLL;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SCROLL: begin
                cmd.scroll_clear = 1'b1;
                if (status.clear_last) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
        out_valid_next = cmd.load_out | (out_valid_reg & ~m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_init_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INIT) |-> !out_valid_reg)
        else $error("result valid during clear sweep");
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!s_ready && state_reg == S_CALC))
        else $error("accepted item did not start");
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> out_valid_reg)
        else $error("loaded result not valid");
`endif

endmodule

### rtl/tcc_datapath.sv
`timescale 1ns / 1ps
// Datapath of the text console engine: screen geometry, ring start, cursor,
// character store with its address unit, and the output register.
// Depends on tcc_pkg; driven by tcc_ctrl commands.
module tcc_datapath #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64,
    parameter int TAB_STOP = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [tcc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_action,
    input  logic [tcc_pkg::CHAR_W-1:0]         s_character,
    input  logic [tcc_pkg::COL_PORT_W-1:0]     s_read_column,
    input  logic [tcc_pkg::ROW_PORT_W-1:0]     s_read_row,
    input  logic                               s_end_of_string,
    output logic [tcc_pkg::CHAR_W-1:0]         m_cell_character,
    output logic [tcc_pkg::COL_PORT_W-1:0]     m_cursor_column,
    output logic [tcc_pkg::ROW_PORT_W-1:0]     m_cursor_row,
    output logic                               m_scrolled,
    output logic                               m_string_done,
    input  tcc_pkg::dp_cmd_t                   cmd,
    output tcc_pkg::dp_status_t                status
);
    import tcc_pkg::*;

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SIZE_W = $clog2(DEPTH + 1);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int WID_W  = $clog2(MAX_COLS + 1);
    localparam int HGT_W  = $clog2(MAX_ROWS + 1);
    localparam int NX_W   = $clog2(MAX_COLS + TAB_STOP);
    localparam int CW     = NX_W + WID_W;
    localparam int RW     = HGT_W + ROW_PORT_W;
    localparam int AROW_W = (HGT_W > ROW_PORT_W) ? HGT_W : ROW_PORT_W;
    localparam int ACOL_W = (COL_W > COL_PORT_W) ? COL_W : COL_PORT_W;
    localparam int SUM_W  = ADDR_W + 2;
    localparam int RST_W_EFF = (RST_WIDTH > MAX_COLS) ? MAX_COLS : RST_WIDTH;
    localparam int RST_H_EFF = (RST_HEIGHT > MAX_ROWS) ? MAX_ROWS : RST_HEIGHT;

    // geometry, ring and cursor
    logic [WID_W-1:0]  eff_w_reg, eff_w_next;
    logic [HGT_W-1:0]  eff_h_reg, eff_h_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [ADDR_W-1:0] ring_reg, ring_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [HGT_W-1:0]  cur_row_reg, cur_row_next;
    logic [ADDR_W-1:0] init_cnt_reg, init_cnt_next;
    logic [WID_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              wr_pend_reg, wr_pend_next;
    logic              scroll_reg, scroll_next;

    // item payload and step registers
    logic                  act_reg;
    logic [CHAR_W-1:0]     char_reg;
    logic [COL_PORT_W-1:0] rcol_reg;
    logic [ROW_PORT_W-1:0] rrow_reg;
    logic                  eos_reg;
    logic [ADDR_W-1:0]     prod_reg;
    logic [ACOL_W-1:0]     acc_col_reg;
    logic [CHAR_W-1:0]     wr_data_reg;
    logic                  in_range_reg;
    logic [CHAR_W-1:0]     rd_data_reg;

    logic [CHAR_W-1:0]     out_cell_reg;
    logic [COL_PORT_W-1:0] out_col_reg;
    logic [ROW_PORT_W-1:0] out_row_reg;
    logic                  out_scrolled_reg;
    logic                  out_eos_reg;

    logic [CHAR_W-1:0] mem [DEPTH];

    logic [NX_W-1:0] tab_tbl [MAX_COLS];

    logic [WIDTH_CFG_W-1:0]  cfg_w;
    logic [HEIGHT_CFG_W-1:0] cfg_h;
    logic                    cfg_hit;

    logic [AROW_W-1:0]       acc_row;
    logic [ACOL_W-1:0]       acc_col;
    logic [CHAR_W-1:0]       wr_data;
    logic                    in_range;
    logic [NX_W-1:0]         tab_nx;
    logic [AROW_W+WID_W-1:0] prod_full;
    logic [WID_W+HGT_W-1:0]  size_full;
    logic [COL_W-1:0]        calc_col;
    logic [HGT_W-1:0]        calc_row;

    logic [SUM_W-1:0]  addr_sum;
    logic [SUM_W-1:0]  addr_wrap;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] ring_plus;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;

    for (genvar g = 0; g < MAX_COLS; g++) begin : g_tab
        assign tab_tbl[g] = NX_W'((g / TAB_STOP + 1) * TAB_STOP);
    end

    assign cfg_w   = cfg_wdata[WIDTH_CFG_W-1:0];
    assign cfg_h   = cfg_wdata[HEIGHT_CFG_W-1:0];
    assign cfg_hit = cfg_wr_en &&
                     (cfg_index == REG_SCREEN_WIDTH || cfg_index == REG_SCREEN_HEIGHT);
    assign tab_nx  = tab_tbl[cur_col_reg];

    // cursor step and access position of one item
    always_comb begin
        acc_row  = AROW_W'(cur_row_reg);
        acc_col  = ACOL_W'(cur_col_reg);
        wr_data  = char_reg;
        calc_col = cur_col_reg;
        calc_row = cur_row_reg;
        wr_pend_next = 1'b0;
        in_range = (CW'(rcol_reg) < CW'(eff_w_reg)) && (RW'(rrow_reg) < RW'(eff_h_reg));
        if (act_reg == ACT_READ) begin
            acc_row = AROW_W'(rrow_reg);
            acc_col = ACOL_W'(rcol_reg);
        end else begin
            case (char_reg)
                CH_LF: begin
                    calc_col = '0;
                    calc_row = cur_row_reg + HGT_W'(1);
                end
                CH_CR: begin
                    calc_col = '0;
                end
                CH_TAB: begin
                    if (CW'(tab_nx) < CW'(eff_w_reg)) begin
                        calc_col = COL_W'(tab_nx);
                    end else begin
                        calc_col = '0;
                        calc_row = cur_row_reg + HGT_W'(1);
                    end
                end
                CH_BS: begin
                    wr_data = '0;
                    if (cur_col_reg != '0) begin
                        calc_col     = cur_col_reg - COL_W'(1);
                        acc_col      = ACOL_W'(calc_col);
                        wr_pend_next = 1'b1;
                    end else if (cur_row_reg != '0) begin
                        calc_row     = cur_row_reg - HGT_W'(1);
                        calc_col     = COL_W'(eff_w_reg - WID_W'(1));
                        acc_row      = AROW_W'(calc_row);
                        acc_col      = ACOL_W'(calc_col);
                        wr_pend_next = 1'b1;
                    end
                end
                default: begin
                    wr_pend_next = 1'b1;
                    if (CW'(cur_col_reg) + CW'(1) >= CW'(eff_w_reg)) begin
                        calc_col = '0;
                        calc_row = cur_row_reg + HGT_W'(1);
                    end else begin
                        calc_col = cur_col_reg + COL_W'(1);
                    end
                end
            endcase
        end
        scroll_next = (act_reg == ACT_WRITE) && (calc_row >= eff_h_reg);
        prod_full   = acc_row * eff_w_reg;
    end

    // store address through the ring offset
    assign addr_sum  = SUM_W'(ring_reg) + SUM_W'(prod_reg) + SUM_W'(acc_col_reg);
    assign addr_wrap = (addr_sum >= SUM_W'(size_reg)) ? addr_sum - SUM_W'(size_reg)
                                                      : addr_sum;
    assign addr      = ADDR_W'(addr_wrap);
    assign ring_plus = SIZE_W'(ring_reg) + SIZE_W'(eff_w_reg);
    assign size_full = eff_w_reg * eff_h_reg;

    always_comb begin
        eff_w_next    = eff_w_reg;
        eff_h_next    = eff_h_reg;
        size_next     = SIZE_W'(size_full);
        ring_next     = ring_reg;
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        init_cnt_next = init_cnt_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_addr_next = clr_addr_reg;
        if (cmd.init_clear) begin
            init_cnt_next = init_cnt_reg + ADDR_W'(1);
        end
        if (cmd.calc && act_reg == ACT_WRITE) begin
            cur_col_next = calc_col;
            cur_row_next = calc_row;
        end
        if (cmd.exec && scroll_reg) begin
            cur_row_next  = eff_h_reg - HGT_W'(1);
            clr_addr_next = ring_reg;
            clr_cnt_next  = '0;
            ring_next     = (ring_plus == size_reg) ? '0 : ADDR_W'(ring_plus);
        end
        if (cmd.scroll_clear) begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            clr_cnt_next  = clr_cnt_reg + WID_W'(1);
        end
        if (cfg_hit) begin
            if (cfg_index == REG_SCREEN_WIDTH) begin
                if (cfg_w == '0) begin
                    eff_w_next = WID_W'(1);
                end else if (CW'(cfg_w) > CW'(MAX_COLS)) begin
                    eff_w_next = WID_W'(MAX_COLS);
                end else begin
                    eff_w_next = WID_W'(cfg_w);
                end
            end else begin
                if (cfg_h == '0) begin
                    eff_h_next = HGT_W'(1);
                end else if (RW'(cfg_h) > RW'(MAX_ROWS)) begin
                    eff_h_next = HGT_W'(MAX_ROWS);
                end else begin
                    eff_h_next = HGT_W'(cfg_h);
                end
            end
            ring_next    = '0;
            cur_col_next = '0;
            cur_row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_w_reg    <= WID_W'(RST_W_EFF);
            eff_h_reg    <= HGT_W'(RST_H_EFF);
            size_reg     <= SIZE_W'(RST_W_EFF * RST_H_EFF);
            ring_reg     <= '0;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            init_cnt_reg <= '0;
            clr_cnt_reg  <= '0;
            clr_addr_reg <= '0;
            wr_pend_reg  <= 1'b0;
            scroll_reg   <= 1'b0;
        end else begin
            eff_w_reg    <= eff_w_next;
            eff_h_reg    <= eff_h_next;
            size_reg     <= size_next;
            ring_reg     <= ring_next;
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            init_cnt_reg <= init_cnt_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_addr_reg <= clr_addr_next;
            if (cmd.calc) begin
                wr_pend_reg <= wr_pend_next;
                scroll_reg  <= scroll_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            act_reg  <= s_action;
            char_reg <= s_character;
            rcol_reg <= s_read_column;
            rrow_reg <= s_read_row;
            eos_reg  <= s_end_of_string;
        end
        if (cmd.calc) begin
            prod_reg     <= ADDR_W'(prod_full);
            acc_col_reg  <= acc_col;
            wr_data_reg  <= wr_data;
            in_range_reg <= in_range;
        end
        if (cmd.load_out) begin
            out_cell_reg     <= (act_reg == ACT_READ && in_range_reg) ? rd_data_reg : '0;
            out_col_reg      <= COL_PORT_W'(cur_col_reg);
            out_row_reg      <= ROW_PORT_W'(cur_row_reg);
            out_scrolled_reg <= scroll_reg;
            out_eos_reg      <= eos_reg;
        end
    end

    // single write port shared by clear sweep, item write and row clear
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr;
        mem_wdata = wr_data_reg;
        if (cmd.init_clear) begin
            mem_we    = 1'b1;
            mem_waddr = init_cnt_reg;
            mem_wdata = '0;
        end else if (cmd.scroll_clear) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else if (cmd.exec && wr_pend_reg) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.exec) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign status.init_last   = (init_cnt_reg == ADDR_W'(DEPTH - 1));
    assign status.need_scroll = scroll_reg;
    assign status.clear_last  = (clr_cnt_reg == eff_w_reg - WID_W'(1));

    assign m_cell_character = out_cell_reg;
    assign m_cursor_column  = out_col_reg;
    assign m_cursor_row     = out_row_reg;
    assign m_scrolled       = out_scrolled_reg;
    assign m_string_done    = out_eos_reg;

`ifndef SYNTHESIS
    a_col_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(cur_col_reg) < CW'(eff_w_reg))
        else $error("cursor column beyond screen width");
    a_ring_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        SIZE_W'(ring_reg) < size_reg)
        else $error("ring start beyond screen size");
    a_write_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && wr_pend_reg) |-> (SIZE_W'(addr) < size_reg))
        else $error("character write beyond screen size");
    a_clear_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scroll_clear |-> (SIZE_W'(clr_addr_reg) < size_reg))
        else $error("row clear beyond screen size");
`endif

endmodule

### rtl/text_console_cursor_scroll.sv
`timescale 1ns / 1ps
// Top level of the text console engine: ring-organized character store with
// cursor, control codes and scroll. Depends on tcc_pkg, tcc_ctrl, tcc_datapath.
//
//   channel   ports                                    handshake
//   input     s_action s_character s_read_column ...   s_valid / s_ready
//   result    m_cell_character m_cursor_column ...     m_valid / m_ready
//   config    cfg_index cfg_wdata                      cfg_wr_en, no wait
//
// An item runs through accept, position/product, store access and result
// load before the next item is accepted. A write that scrolls also clears
// the new last row, cell by cell, through the store's single write port.
// After reset a clearing pass over all MAX_COLS*MAX_ROWS cells (8192 by default)
// holds s_ready low. The result register keeps a result while the next item
// runs; an item only stalls at its load step while m_ready is low.
module text_console_cursor_scroll #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64,
    parameter int TAB_STOP = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [tcc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_action,
    input  logic [tcc_pkg::CHAR_W-1:0]         s_character,
    input  logic [tcc_pkg::COL_PORT_W-1:0]     s_read_column,
    input  logic [tcc_pkg::ROW_PORT_W-1:0]     s_read_row,
    input  logic                               s_end_of_string,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [tcc_pkg::CHAR_W-1:0]         m_cell_character,
    output logic [tcc_pkg::COL_PORT_W-1:0]     m_cursor_column,
    output logic [tcc_pkg::ROW_PORT_W-1:0]     m_cursor_row,
    output logic                               m_scrolled,
    output logic                               m_string_done
);
    import tcc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    tcc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tcc_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_action         (s_action),
        .s_character      (s_character),
        .s_read_column    (s_read_column),
        .s_read_row       (s_read_row),
        .s_end_of_string  (s_end_of_string),
        .m_cell_character (m_cell_character),
        .m_cursor_column  (m_cursor_column),
        .m_cursor_row     (m_cursor_row),
        .m_scrolled       (m_scrolled),
        .m_string_done    (m_string_done),
        .cmd              (cmd),
        .status           (status)
    );

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Testbench for text_console_cursor_scroll: writes characters and control codes,
// reads back screen cells and checks each result against a local screen model.
// Depends on tcc_pkg and the RTL of text_console_cursor_scroll.
module tb;
    import tcc_pkg::*;

    localparam int MAX_COLS  = 128;
    localparam int MAX_ROWS  = 64;
    localparam int TAB_STOP  = 4;
    localparam int STORE_LEN = MAX_COLS * MAX_ROWS;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

    typedef struct packed {
        logic                  action;
        logic [CHAR_W-1:0]     character;
        logic [COL_PORT_W-1:0] read_col;
        logic [ROW_PORT_W-1:0] read_row;
        logic                  eos;
    } console_req_t;

    typedef struct packed {
        logic [CHAR_W-1:0]     cell_char;
        logic [COL_PORT_W-1:0] col;
        logic [ROW_PORT_W-1:0] row;
        logic                  scrolled;
        logic                  done;
    } console_status_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_action;
    logic [CHAR_W-1:0]     s_character;
    logic [COL_PORT_W-1:0] s_read_column;
    logic [ROW_PORT_W-1:0] s_read_row;
    logic                  s_end_of_string;
    logic                  m_valid;
    logic                  m_ready;
    logic [CHAR_W-1:0]     m_cell_character;
    logic [COL_PORT_W-1:0] m_cursor_column;
    logic [ROW_PORT_W-1:0] m_cursor_row;
    logic                  m_scrolled;
    logic                  m_string_done;

    text_console_cursor_scroll #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS),
        .TAB_STOP(TAB_STOP)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_character     (s_character),
        .s_read_column   (s_read_column),
        .s_read_row      (s_read_row),
        .s_end_of_string (s_end_of_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cell_character(m_cell_character),
        .m_cursor_column (m_cursor_column),
        .m_cursor_row    (m_cursor_row),
        .m_scrolled      (m_scrolled),
        .m_string_done   (m_string_done)
    );

    // screen model
    logic [CHAR_W-1:0]       screen_cells [STORE_LEN];
    int unsigned             ring_ofs;
    int unsigned             cur_x;
    int unsigned             cur_y;
    logic [WIDTH_CFG_W-1:0]  reg_width;
    logic [HEIGHT_CFG_W-1:0] reg_height;

    console_status_t pending_status [$];
    int              error_count = 0;
    int              send_idle_pct = 33;
    int              recv_idle_pct = 49;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("tb: errors");
        $finish;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic int unsigned cols_in_use();
        if (reg_width < 1) return 1;
        if (reg_width > MAX_COLS) return MAX_COLS;
        return reg_width;
    endfunction

    function automatic int unsigned rows_in_use();
        if (reg_height < 1) return 1;
        if (reg_height > MAX_ROWS) return MAX_ROWS;
        return reg_height;
    endfunction

    function automatic int unsigned cell_slot(input int unsigned col, input int unsigned row);
        return (ring_ofs + row * cols_in_use() + col) % (cols_in_use() * rows_in_use());
    endfunction

    function automatic void screen_reset();
        foreach (screen_cells[i]) screen_cells[i] = '0;
        ring_ofs   = 0;
        cur_x      = 0;
        cur_y      = 0;
        reg_width  = WIDTH_CFG_W'(RST_WIDTH);
        reg_height = HEIGHT_CFG_W'(RST_HEIGHT);
    endfunction

    function automatic void screen_configure(input logic [CFG_IDX_W-1:0] idx,
                                             input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SCREEN_WIDTH:  reg_width = data[WIDTH_CFG_W-1:0];
            REG_SCREEN_HEIGHT: reg_height = data[HEIGHT_CFG_W-1:0];
            default:           return;
        endcase
        ring_ofs = 0;
        cur_x    = 0;
        cur_y    = 0;
    endfunction

    function automatic console_status_t screen_apply(input console_req_t req);
        int unsigned     w;
        int unsigned     h;
        int unsigned     nx;
        console_status_t st;
        w = cols_in_use();
        h = rows_in_use();
        st = '0;
        st.done = req.eos;
        if (req.action == ACT_READ) begin
            if (req.read_col < w && req.read_row < h)
                st.cell_char = screen_cells[cell_slot(req.read_col, req.read_row)];
        end else begin
            case (req.character)
                CH_LF: begin
                    cur_x = 0;
                    cur_y++;
                end
                CH_CR: begin
                    cur_x = 0;
                end
                CH_TAB: begin
                    nx = cur_x + TAB_STOP - (cur_x % TAB_STOP);
                    if (nx < w) begin
                        cur_x = nx;
                    end else begin
                        cur_x = 0;
                        cur_y++;
                    end
                end
                CH_BS: begin
                    if (cur_x > 0) begin
                        cur_x--;
                        screen_cells[cell_slot(cur_x, cur_y)] = '0;
                    end else if (cur_y > 0) begin
                        cur_y--;
                        cur_x = w - 1;
                        screen_cells[cell_slot(cur_x, cur_y)] = '0;
                    end
                end
                default: begin
                    screen_cells[cell_slot(cur_x, cur_y)] = req.character;
                    cur_x++;
                    if (cur_x >= w) begin
                        cur_x = 0;
                        cur_y++;
                    end
                end
            endcase
            if (cur_y >= h) begin
                ring_ofs = (ring_ofs + w) % (w * h);
                for (int c = 0; c < w; c++) screen_cells[cell_slot(c, h - 1)] = '0;
                cur_y = h - 1;
                st.scrolled = 1'b1;
            end
        end
        st.col = cur_x[COL_PORT_W-1:0];
        st.row = cur_y[ROW_PORT_W-1:0];
        return st;
    endfunction

    function automatic console_req_t write_req(input logic [CHAR_W-1:0] ch, input logic eos);
        console_req_t req;
        req = '0;
        req.action    = ACT_WRITE;
        req.character = ch;
        req.read_col  = COL_PORT_W'($urandom);
        req.read_row  = ROW_PORT_W'($urandom);
        req.eos       = eos;
        return req;
    endfunction

    function automatic console_req_t read_req(input int unsigned col, input int unsigned row);
        console_req_t req;
        req = '0;
        req.action    = ACT_READ;
        req.character = CHAR_W'($urandom);
        req.read_col  = col[COL_PORT_W-1:0];
        req.read_row  = row[ROW_PORT_W-1:0];
        req.eos       = 1'($urandom);
        return req;
    endfunction

    function automatic console_req_t random_req();
        int unsigned w;
        int unsigned h;
        int unsigned pick;
        logic [CHAR_W-1:0] ch;
        w = cols_in_use();
        h = rows_in_use();
        if ($urandom_range(99) < 28) begin
            if ($urandom_range(3) == 0)
                return read_req($urandom_range(127), $urandom_range(63));
            return read_req($urandom_range(w - 1), $urandom_range(h - 1));
        end
        pick = $urandom_range(99);
        if (pick < 8)       ch = CH_LF;
        else if (pick < 12) ch = CH_CR;
        else if (pick < 18) ch = CH_TAB;
        else if (pick < 28) ch = CH_BS;
        else if (pick < 30) ch = '0;
        else                ch = CHAR_W'($urandom);
        return write_req(ch, 1'($urandom));
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        error_count++;
    endtask

    task automatic send_item(input console_req_t req);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_action        = req.action;
        s_character     = req.character;
        s_read_column   = req.read_col;
        s_read_row      = req.read_row;
        s_end_of_string = req.eos;
        do @(posedge aclk); while (!s_ready);
        pending_status.push_back(screen_apply(req));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_status.size() != 0) @(negedge aclk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        repeat (8) @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        screen_configure(idx, data);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    always @(posedge aclk) begin
        console_status_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                report_mismatch("result with nothing pending");
            end else begin
                want = pending_status.pop_front();
                if (m_cell_character !== want.cell_char)
                    report_mismatch($sformatf("cell_character %h, want %h",
                                              m_cell_character, want.cell_char));
                if (m_cursor_column !== want.col)
                    report_mismatch($sformatf("cursor_column %0d, want %0d",
                                              m_cursor_column, want.col));
                if (m_cursor_row !== want.row)
                    report_mismatch($sformatf("cursor_row %0d, want %0d",
                                              m_cursor_row, want.row));
                if (m_scrolled !== want.scrolled)
                    report_mismatch($sformatf("scrolled %b, want %b",
                                              m_scrolled, want.scrolled));
                if (m_string_done !== want.done)
                    report_mismatch($sformatf("string_done %b, want %b",
                                              m_string_done, want.done));
            end
        end
    end

    task automatic test_default_screen();
        send_item(write_req(16'h0041, 1'b1));
        send_item(read_req(0, 0));
        send_item(read_req(79, 24));
        send_item(read_req(80, 0));
        send_item(read_req(0, 25));
        send_item(read_req(127, 63));
    endtask

    task automatic test_control_codes();
        set_register(REG_SCREEN_WIDTH, 8'd10);
        set_register(REG_SCREEN_HEIGHT, 8'd3);
        send_item(write_req(CH_BS, 1'b0));
        send_item(write_req(16'h0048, 1'b0));
        send_item(write_req(16'h0069, 1'b0));
        send_item(write_req(CH_TAB, 1'b0));
        send_item(write_req(CH_TAB, 1'b0));
        send_item(write_req(CH_TAB, 1'b0));
        send_item(write_req(CH_BS, 1'b0));
        send_item(write_req(16'h0000, 1'b0));
        send_item(write_req(16'hFFFF, 1'b1));
        send_item(write_req(CH_CR, 1'b0));
        send_item(write_req(CH_LF, 1'b0));
        send_item(write_req(CH_LF, 1'b1));
        send_item(read_req(0, 0));
        send_item(read_req(1, 0));
        send_item(read_req(9, 0));
        send_item(read_req(10, 0));
        send_item(read_req(0, 3));
        send_item(write_req(CH_BS, 1'b0));
    endtask

    task automatic test_register_extremes();
        // zero width and height act as a single cell
        set_register(REG_SCREEN_WIDTH, 8'd0);
        set_register(REG_SCREEN_HEIGHT, 8'd0);
        send_item(write_req(16'h0078, 1'b0));
        send_item(read_req(0, 0));
        send_item(write_req(CH_BS, 1'b0));
        // oversized values clamp to the full store
        set_register(REG_SCREEN_WIDTH, 8'hFF);
        set_register(REG_SCREEN_HEIGHT, 8'hFF);
        send_item(write_req(CH_TAB, 1'b0));
        send_item(write_req(16'h0041, 1'b1));
        send_item(read_req(127, 63));
        send_item(read_req(4, 0));
        // unused indexes leave cursor and geometry alone
        set_register(REG_UNUSED_A, 8'h55);
        set_register(REG_UNUSED_B, 8'hAA);
        send_item(write_req(16'h0042, 1'b0));
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int mode);
        logic [CFG_DATA_W-1:0] w_val;
        logic [CFG_DATA_W-1:0] h_val;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int chunk = 0; chunk < 4; chunk++) begin
            case (chunk)
                0: begin
                    w_val = CFG_DATA_W'($urandom_range(1, 12));
                    h_val = CFG_DATA_W'($urandom_range(1, 6));
                end
                1: begin
                    w_val = CFG_DATA_W'($urandom_range(1, 128));
                    h_val = CFG_DATA_W'($urandom_range(1, 64));
                end
                2: begin
                    w_val = (mode == 0) ? 8'hFF : (mode == 1) ? 8'd0 : 8'd128;
                    h_val = (mode == 0) ? 8'hFF : (mode == 1) ? 8'd0 : 8'd1;
                end
                default: begin
                    w_val = (mode == 0) ? 8'd1 : (mode == 1) ? 8'd128 : 8'd1;
                    h_val = (mode == 0) ? 8'd8 : (mode == 1) ? 8'd64 : 8'd64;
                end
            endcase
            set_register(REG_SCREEN_WIDTH, w_val);
            set_register(REG_SCREEN_HEIGHT, h_val);
            for (int n = 0; n < 75; n++) begin
                // hold off once until the block has caught up
                if (chunk == 1 && n == 37) wait_drained();
                send_item(random_req());
            end
        end
    endtask

    initial begin
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = REG_SCREEN_WIDTH;
        cfg_wdata       = '0;
        s_valid         = 1'b0;
        s_action        = ACT_WRITE;
        s_character     = '0;
        s_read_column   = '0;
        s_read_row      = '0;
        s_end_of_string = 1'b0;
        screen_reset();
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        test_default_screen();
        test_control_codes();
        test_register_extremes();
        test_random_traffic(33, 49, 0);
        test_random_traffic(49, 33, 1);
        test_random_traffic(0, 0, 2);

        wait_drained();
        repeat (200) @(negedge aclk);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

### filelist.f
rtl/tcc_pkg.sv
rtl/tcc_ctrl.sv
rtl/tcc_datapath.sv
rtl/text_console_cursor_scroll.sv
sim/tb.sv
